### rtl/core/salru_pkg.sv
`default_nettype none

package salru_pkg;

  // Geometry of the tag store.
  localparam int unsigned MAX_WAYS  = 4;
  localparam int unsigned MAX_SETS  = 512;
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned WAY_W  = 2;
  localparam int unsigned SET_W  = $clog2(MAX_SETS);
  localparam int unsigned RANK_W = 2;

  // Block size limits and the resulting tag width (the whole block number).
  localparam int unsigned MIN_SHIFT = 4;
  localparam int unsigned MAX_SHIFT = 6;
  localparam int unsigned TAG_W     = ADDR_BITS - MIN_SHIFT;

  localparam int unsigned COUNT_W = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned WAYS_CFG_W  = 3;
  localparam int unsigned SHIFT_CFG_W = 3;
  localparam int unsigned SLOG_CFG_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAY_COUNT   = 2'd0,
    CFG_BLOCK_SHIFT = 2'd1,
    CFG_SET_LOG2    = 2'd2
  } cfg_idx_e;

  localparam logic [WAYS_CFG_W-1:0]  WAY_COUNT_RST   = 3'd4;
  localparam logic [SHIFT_CFG_W-1:0] BLOCK_SHIFT_RST = 3'd4;
  localparam logic [SLOG_CFG_W-1:0]  SET_LOG2_RST    = 4'd6;

  // One row of the tag store holds every way of one set.
  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0]             valid;
  } row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             lookup;
    logic             commit;
    logic             clr_we;
    logic [SET_W-1:0] clr_addr;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/salru_ctrl.sv
`default_nettype none

module salru_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output salru_pkg::cmd_t  cmd_o
);
  import salru_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [SET_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    clr_cnt_d      = clr_cnt_q;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_cnt_d    = clr_cnt_q + SET_W'(1);
        if (clr_cnt_q == SET_W'(MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.lookup = 1'b1;
          state_d      = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // The result register must be free, or emptied in this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/salru_dp.sv
`default_nettype none

module salru_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [salru_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [salru_pkg::ADDR_BITS-1:0]     in_address_i,
  input  salru_pkg::cmd_t                     cmd_i,
  output logic                                out_hit_o,
  output logic [salru_pkg::WAY_W-1:0]         out_way_used_o,
  output logic                                out_evicted_valid_o,
  output logic [salru_pkg::COUNT_W-1:0]       out_miss_count_o
);
  import salru_pkg::*;

  logic [WAYS_CFG_W-1:0]  way_count_q;
  logic [SHIFT_CFG_W-1:0] block_shift_q;
  logic [SLOG_CFG_W-1:0]  set_log2_q;

  logic [WAYS_CFG_W-1:0]  ways_eff;
  logic [SHIFT_CFG_W-1:0] shift_eff;
  logic [SLOG_CFG_W-1:0]  slog_eff;
  logic [SET_W-1:0]       set_mask;
  logic [TAG_W-1:0]       block;
  logic [SET_W-1:0]       set_idx;

  logic [TAG_W-1:0]       block_q;
  logic [SET_W-1:0]       set_q;
  row_t                   mem [MAX_SETS];
  row_t                   row_q;
  row_t                   new_row;

  logic [MAX_WAYS-1:0]    in_use;
  logic [MAX_WAYS-1:0]    tag_hit;
  logic [MAX_WAYS-1:0]    free_way;
  logic                   hit;
  logic                   found;
  logic                   evict;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       fill_way;
  logic [WAY_W-1:0]       vic_way;
  logic [WAY_W-1:0]       way_sel;
  logic [RANK_W-1:0]      best;
  logic [RANK_W-1:0]      old_rank;
  logic [RANK_W-1:0]      fill_rank;

  logic [COUNT_W-1:0]     miss_cnt_q;
  logic                   hit_q;
  logic [WAY_W-1:0]       way_q;
  logic                   evict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_count_q   <= WAY_COUNT_RST;
      block_shift_q <= BLOCK_SHIFT_RST;
      set_log2_q    <= SET_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAY_COUNT:   way_count_q   <= cfg_data_i[WAYS_CFG_W-1:0];
        CFG_BLOCK_SHIFT: block_shift_q <= cfg_data_i[SHIFT_CFG_W-1:0];
        CFG_SET_LOG2:    set_log2_q    <= cfg_data_i[SLOG_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values outside their range are clamped.
  always_comb begin
    if (way_count_q == '0) begin
      ways_eff = WAYS_CFG_W'(1);
    end else if (way_count_q > WAYS_CFG_W'(MAX_WAYS)) begin
      ways_eff = WAYS_CFG_W'(MAX_WAYS);
    end else begin
      ways_eff = way_count_q;
    end

    if (block_shift_q < SHIFT_CFG_W'(MIN_SHIFT)) begin
      shift_eff = SHIFT_CFG_W'(MIN_SHIFT);
    end else if (block_shift_q > SHIFT_CFG_W'(MAX_SHIFT)) begin
      shift_eff = SHIFT_CFG_W'(MAX_SHIFT);
    end else begin
      shift_eff = block_shift_q;
    end

    if (set_log2_q > SLOG_CFG_W'(SET_W)) begin
      slog_eff = SLOG_CFG_W'(SET_W);
    end else begin
      slog_eff = set_log2_q;
    end
  end

  assign block    = TAG_W'(in_address_i >> shift_eff);
  assign set_mask = ~({SET_W{1'b1}} << slog_eff);
  assign set_idx  = block[SET_W-1:0] & set_mask;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      block_q <= block;
      set_q   <= set_idx;
    end
  end

  // Tag store: one write port shared by the clearing pass and the update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      mem[cmd_i.clr_addr] <= '0;
    end else if (cmd_i.commit) begin
      mem[set_q] <= new_row;
    end
    if (cmd_i.lookup) begin
      row_q <= mem[set_idx];
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = WAYS_CFG_W'(w) < ways_eff;
      tag_hit[w]  = in_use[w] && row_q.valid[w] && (row_q.tag[w] == block_q);
      free_way[w] = in_use[w] && !row_q.valid[w];
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    found    = 1'b0;
    fill_way = '0;
    best     = '0;
    vic_way  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (tag_hit[w] && !hit) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (free_way[w] && !found) begin
        found    = 1'b1;
        fill_way = WAY_W'(w);
      end
      if (in_use[w] && (row_q.rank[w] > best)) begin
        best    = row_q.rank[w];
        vic_way = WAY_W'(w);
      end
    end
  end

  // A block filled into a free way enters below every other valid way.
  always_comb begin
    fill_rank = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && row_q.valid[w] && (WAY_W'(w) != fill_way)) begin
        fill_rank = fill_rank + RANK_W'(1);
      end
    end
  end

  always_comb begin
    evict = 1'b0;
    if (hit) begin
      way_sel  = hit_way;
      old_rank = row_q.rank[hit_way];
    end else if (found) begin
      way_sel  = fill_way;
      old_rank = fill_rank;
    end else begin
      way_sel  = vic_way;
      old_rank = best;
      evict    = 1'b1;
    end

    new_row = row_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if ((WAY_W'(w) != way_sel) && in_use[w] && row_q.valid[w] &&
          (row_q.rank[w] < old_rank)) begin
        new_row.rank[w] = row_q.rank[w] + RANK_W'(1);
      end
    end
    new_row.rank[way_sel] = '0;
    if (!hit) begin
      new_row.tag[way_sel]   = block_q;
      new_row.valid[way_sel] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_cnt_q <= '0;
    end else if (cmd_i.commit && !hit && (miss_cnt_q != '1)) begin
      miss_cnt_q <= miss_cnt_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q   <= hit;
      way_q   <= way_sel;
      evict_q <= evict;
    end
  end

  assign out_hit_o           = hit_q;
  assign out_way_used_o      = way_q;
  assign out_evicted_valid_o = evict_q;
  // The counter only moves at a commit, which waits until the result is free.
  assign out_miss_count_o    = miss_cnt_q;

endmodule

`default_nettype wire

### rtl/core/set_assoc_cache_lru_miss_counter.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i                cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_stall_o in_address_i
// out       out        out_valid_o / out_stall_i
//                                              out_hit_o, out_way_used_o,
//                                              out_evicted_valid_o, out_miss_count_o
//
// One transaction: the set row is read from the tag store in the cycle of
// acceptance, and the LRU update and write-back follow once the result register
// is free; the input stays stalled until then, so one input is taken at a time.
// After reset the tag store is cleared, all 512 sets, one set per cycle, with
// the input stalled; configuration writes are taken during that time.
// A stalled result holds in its register; one more input may be accepted and
// waits for its write-back until the result is taken.

module set_assoc_cache_lru_miss_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [salru_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [salru_pkg::ADDR_BITS-1:0]   in_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              out_hit_o,
  output logic [salru_pkg::WAY_W-1:0]       out_way_used_o,
  output logic                              out_evicted_valid_o,
  output logic [salru_pkg::COUNT_W-1:0]     out_miss_count_o
);
  import salru_pkg::*;

  // The controller sequences clearing, lookup and commit; the datapath holds
  // the configuration, the row memory, the LRU update and the miss counter.
  cmd_t cmd;

  salru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  salru_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_address_i        (in_address_i),
    .cmd_i               (cmd),
    .out_hit_o           (out_hit_o),
    .out_way_used_o      (out_way_used_o),
    .out_evicted_valid_o (out_evicted_valid_o),
    .out_miss_count_o    (out_miss_count_o)
  );

endmodule

`default_nettype wire

### rtl/core/salru_checker.sv
`default_nettype none

module salru_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic                              out_hit_o,
  input  logic [salru_pkg::WAY_W-1:0]       out_way_used_o,
  input  logic                              out_evicted_valid_o,
  input  logic [salru_pkg::COUNT_W-1:0]     out_miss_count_o
);
  import salru_pkg::*;

  logic               out_take;
  logic [COUNT_W-1:0] last_cnt_q;

  assign out_take = out_valid_o && !out_stall_i;

  // Miss count of the last transaction delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (out_take) begin
      last_cnt_q <= out_miss_count_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_hit_o) &&
      $stable(out_way_used_o) && $stable(out_evicted_valid_o) &&
      $stable(out_miss_count_o))
    else $error("result changed while stalled");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input accepted during the clearing pass");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_hit_o |-> !out_evicted_valid_o)
    else $error("hit reported an eviction");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_hit_o |-> out_miss_count_o == last_cnt_q)
    else $error("miss count moved on a hit");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !out_hit_o |->
      (out_miss_count_o == COUNT_W'(last_cnt_q + COUNT_W'(1))) ||
      ((last_cnt_q == '1) && (out_miss_count_o == '1)))
    else $error("miss count did not advance by one on a miss");

endmodule

bind set_assoc_cache_lru_miss_counter salru_checker u_salru_checker (.*);

`default_nettype wire

### bench/cache_lru_checker.sv
module cache_lru_checker
  import salru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ADDR_BITS-1:0] in_address_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 out_hit_i,
  input  logic [WAY_W-1:0]     out_way_used_i,
  input  logic                 out_evicted_valid_i,
  input  logic [COUNT_W-1:0]   out_miss_count_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   hits_o,
  output int                   evictions_o
);

  localparam int unsigned ENTRIES     = MAX_SETS * MAX_WAYS;
  localparam int          SHOWN_FAILS = 10;

  typedef struct packed {
    logic               hit;
    logic [WAY_W-1:0]   way;
    logic               evicted;
    logic [COUNT_W-1:0] misses;
  } lookup_t;

  // Shadow copy of the tag store, the replacement ranks and the registers.
  logic [TAG_W-1:0]       tag_mem   [ENTRIES];
  logic                   valid_mem [ENTRIES];
  logic [RANK_W-1:0]      rank_mem  [ENTRIES];
  logic [COUNT_W-1:0]     miss_total;
  logic [WAYS_CFG_W-1:0]  way_count_q;
  logic [SHIFT_CFG_W-1:0] block_shift_q;
  logic [SLOG_CFG_W-1:0]  set_log2_q;

  lookup_t lookup_q [$];
  int      fails;
  int      checked;
  int      hits;
  int      evictions;

  // Performs one access on the shadow store and returns what the block must report.
  function automatic lookup_t access_block(input logic [ADDR_BITS-1:0] addr);
    int unsigned      ways;
    int unsigned      shift;
    int unsigned      slog;
    int unsigned      base;
    int unsigned      way;
    int unsigned      old_rank;
    int unsigned      w;
    logic [ADDR_BITS-1:0] blk;
    logic             found;
    lookup_t          res;

    ways = way_count_q;
    if (ways < 1) ways = 1;
    else if (ways > MAX_WAYS) ways = MAX_WAYS;
    shift = block_shift_q;
    if (shift < MIN_SHIFT) shift = MIN_SHIFT;
    else if (shift > MAX_SHIFT) shift = MAX_SHIFT;
    slog = set_log2_q;
    if (slog > SET_W) slog = SET_W;

    blk  = addr >> shift;
    base = (blk & ((32'd1 << slog) - 32'd1)) * MAX_WAYS;
    res  = '0;
    way  = 0;

    for (w = 0; w < ways; w++) begin
      if (!res.hit && valid_mem[base+w] && tag_mem[base+w] == blk[TAG_W-1:0]) begin
        res.hit = 1'b1;
        way     = w;
      end
    end

    if (res.hit) begin
      old_rank = rank_mem[base+way];
    end else begin
      if (miss_total != '1) miss_total++;
      found = 1'b0;
      for (w = 0; w < ways; w++) begin
        if (!found && !valid_mem[base+w]) begin
          found = 1'b1;
          way   = w;
        end
      end
      old_rank = 0;
      if (found) begin
        // The new block goes in behind every valid way in use.
        for (w = 0; w < ways; w++)
          if (w != way && valid_mem[base+w]) old_rank++;
      end else begin
        // Oldest way wins; a tie goes to the lowest index.
        for (w = 0; w < ways; w++) begin
          if (rank_mem[base+w] > old_rank) begin
            old_rank = rank_mem[base+w];
            way      = w;
          end
        end
        res.evicted = 1'b1;
      end
      tag_mem[base+way]   = blk[TAG_W-1:0];
      valid_mem[base+way] = 1'b1;
    end

    for (w = 0; w < ways; w++)
      if (w != way && valid_mem[base+w] && rank_mem[base+w] < old_rank) rank_mem[base+w]++;
    rank_mem[base+way] = '0;

    res.way    = way[WAY_W-1:0];
    res.misses = miss_total;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= SHOWN_FAILS)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", checked, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lookup_t want;
    int      e;

    if (!rst_ni) begin
      for (e = 0; e < ENTRIES; e++) begin
        tag_mem[e]   = '0;
        valid_mem[e] = 1'b0;
        rank_mem[e]  = '0;
      end
      miss_total    = '0;
      way_count_q   = WAY_COUNT_RST;
      block_shift_q = BLOCK_SHIFT_RST;
      set_log2_q    = SET_LOG2_RST;
      lookup_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAY_COUNT:   way_count_q   = cfg_data_i[WAYS_CFG_W-1:0];
          CFG_BLOCK_SHIFT: block_shift_q = cfg_data_i[SHIFT_CFG_W-1:0];
          CFG_SET_LOG2:    set_log2_q    = cfg_data_i[SLOG_CFG_W-1:0];
          default: ;
        endcase
      end

      // Results leave in a later cycle than their access, so compare before predicting.
      if (out_valid_i && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          fails++;
          if (fails <= SHOWN_FAILS)
            $display("result with no access outstanding: hit %0b way %0d evicted %0b misses %0d",
                     out_hit_i, out_way_used_i, out_evicted_valid_i, out_miss_count_i);
        end else begin
          want = lookup_q.pop_front();
          check_field("hit", COUNT_W'(want.hit), COUNT_W'(out_hit_i));
          check_field("way_used", COUNT_W'(want.way), COUNT_W'(out_way_used_i));
          check_field("evicted_valid", COUNT_W'(want.evicted), COUNT_W'(out_evicted_valid_i));
          check_field("miss_count", want.misses, out_miss_count_i);
          if (want.hit) hits++;
          if (want.evicted) evictions++;
          checked++;
        end
      end

      if (in_valid_i && !in_stall_i) lookup_q.push_back(access_block(in_address_i));
    end

    fail_count_o <= fails;
    pending_o    <= lookup_q.size();
    checked_o    <= checked;
    hits_o       <= hits;
    evictions_o  <= evictions;
  end

endmodule

### bench/tb.sv
module tb;
  import salru_pkg::*;

  // Cycles the receiver refuses results once, long enough that the block
  // holds a result, takes one more access and then stalls its input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles without any transaction before the run is declared hung. The
  // clearing pass after reset (one set per cycle) and the hold-off both fit
  // well inside it.
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int          HOT_BLOCKS  = 8;
  localparam int          PHASE_ITEMS = 110;
  localparam int          N_SETTINGS  = 8;
  localparam int          PRESSURE_PHASE = 2;
  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // Register settings of the random phases: way count, block shift, set count
  // log2. They include the smallest and largest legal values and values out of
  // range (on both sides for way count and shift), which the block must clamp.
  localparam int unsigned SET_WAYS  [N_SETTINGS] = '{1, 4, 2, 0, 7, 3, 4, 2};
  localparam int unsigned SET_SHIFT [N_SETTINGS] = '{4, 6, 5, 3, 7, 0, 4, 6};
  localparam int unsigned SET_SLOG  [N_SETTINGS] = '{0, 9, 3, 2, 15, 1, 10, 5};

  // Directed accesses under the reset settings (4 ways, 16-byte blocks,
  // 64 sets, so addresses 1 KiB apart share a set): address extremes, a hit
  // inside a block, filling every way of one set, a hit that reorders the
  // ranks, two evictions of the oldest way, and alternating bit patterns.
  localparam logic [ADDR_BITS-1:0] DIRECTED [14] = '{
    32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
    32'h0000_0400, 32'h0000_0800, 32'h0000_0C00, 32'h0000_0000,
    32'h0000_1000, 32'h0000_0400, 32'h0000_0C0C, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hAAAA_AAA0
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [ADDR_BITS-1:0] in_address;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic [WAY_W-1:0]     out_way_used;
  logic                 out_evicted_valid;
  logic [COUNT_W-1:0]   out_miss_count;

  int fail_count;
  int pending;
  int checked;
  int hits;
  int evictions;

  logic                 hold_req = 1'b0;
  int unsigned          idle_cycles = 0;
  logic [ADDR_BITS-1:0] hot_addr [HOT_BLOCKS];

  always #5 clk = ~clk;

  set_assoc_cache_lru_miss_counter dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_address_i        (in_address),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_hit_o           (out_hit),
    .out_way_used_o      (out_way_used),
    .out_evicted_valid_o (out_evicted_valid),
    .out_miss_count_o    (out_miss_count)
  );

  // The checker watches both channels and the register port, predicts every
  // result and hands its counts back here.
  cache_lru_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_address_i        (in_address),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_hit_i           (out_hit),
    .out_way_used_i      (out_way_used),
    .out_evicted_valid_i (out_evicted_valid),
    .out_miss_count_i    (out_miss_count),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .checked_o           (checked),
    .hits_o              (hits),
    .evictions_o         (evictions)
  );

  // A block-aligned address from a small region: at most four sets at every block
  // size, with few distinct tags, so that accesses collide, hit and evict.
  function automatic logic [ADDR_BITS-1:0] hot_block();
    return (ADDR_BITS'($urandom_range(31, 0)) << 15) | (ADDR_BITS'($urandom_range(3, 0)) << 6);
  endfunction

  // Offers one access and holds it until the block takes the transaction.
  // The caller is always at a rising edge, and valid stays high on return so
  // that back-to-back accesses need no extra assignment.
  task automatic send_access(input logic [ADDR_BITS-1:0] addr);
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Stops offering, waits until every result has come back and then waits on,
  // so the last write-back has surely landed before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: segments of random length, each with its own stall rate, some
  // of them never stalling. On request it refuses results for a long stretch,
  // once.
  initial begin : rx_pattern
    int unsigned seg_left;
    int unsigned duty;
    int unsigned held;
    logic        hold_done;

    seg_left  = 0;
    duty      = 0;
    held      = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (held > 0) begin
        held--;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        held      = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(150, 10);
          duty     = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(80, 5);
        end
        seg_left--;
        out_stall <= ($urandom_range(99, 0) < duty);
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding", IDLE_LIMIT, pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          ph;
    int          left;
    int          burst;
    int          k;
    int unsigned pick;
    logic [ADDR_BITS-1:0] addr;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_WAY_COUNT;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_address <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clearing pass is still running here; register writes are taken.
    write_reg(CFG_IDX_SPARE, '1);
    cfg_we <= 1'b0;

    // Directed part, back to back so that same-set accesses follow each other.
    foreach (DIRECTED[i]) send_access(DIRECTED[i]);

    for (ph = 0; ph < N_SETTINGS; ph++) begin
      drain();
      write_reg(CFG_WAY_COUNT, CFG_W'(SET_WAYS[ph]));
      write_reg(CFG_BLOCK_SHIFT, CFG_W'(SET_SHIFT[ph]));
      write_reg(CFG_SET_LOG2, CFG_W'(SET_SLOG[ph]));
      cfg_we <= 1'b0;
      foreach (hot_addr[i]) hot_addr[i] = hot_block();
      if (ph == PRESSURE_PHASE) hold_req <= 1'b1;

      // Mostly reuse of a small working set with random offsets inside the
      // block, some of it replaced now and then, plus fully random addresses.
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(40, 1);
        if (ph == PRESSURE_PHASE) burst = left;
        if (burst > left) burst = left;
        repeat (burst) begin
          pick = $urandom_range(99, 0);
          if (pick < 10) begin
            addr = $urandom;
          end else begin
            k = $urandom_range(HOT_BLOCKS - 1, 0);
            if (pick < 30) hot_addr[k] = hot_block();
            addr = hot_addr[k] | ADDR_BITS'($urandom_range(15, 0));
          end
          send_access(addr);
        end
        left -= burst;
        if (left > 0 && $urandom_range(2, 0) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(12, 1)) @(posedge clk);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("checked %0d lookups: %0d hits, %0d evictions, across %0d register settings",
             checked, hits, evictions, N_SETTINGS + 1);
    $display("settings included clamped values; output held off for %0d cycles once",
             HOLD_CYCLES);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
